// ----- design/dcr_pkg.sv -----
// Package with shared widths, status codes and the result record of the chaddr rewriter.
`timescale 1ns / 1ps
package dcr_pkg;

	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 16;
	localparam int STATUS_W = 3;
	localparam int CSUM_W   = 16;
	localparam int OFFS_W   = 7;
	localparam int MAC_W    = 48;

	// Status codes reported on the final byte of a packet.
	localparam logic [STATUS_W-1:0] ST_REWRITTEN  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_SHORT  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_HEADER = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_UDP    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_DHCP   = 3'd4;

	// Protocol constants.
	localparam logic [BYTE_W-1:0] PROTO_UDP      = 8'h11;
	localparam logic [LEN_W-1:0]  MIN_IP_HDR     = 16'd20;
	localparam logic [LEN_W-1:0]  UDP_HDR_BYTES  = 16'd8;
	localparam logic [LEN_W-1:0]  DHCP_FIXED     = 16'd236;
	localparam logic [LEN_W-1:0]  MIN_PACKET     = MIN_IP_HDR + UDP_HDR_BYTES + DHCP_FIXED;
	localparam logic [LEN_W-1:0]  PORT_CLIENT    = 16'd68;
	localparam logic [LEN_W-1:0]  PORT_SERVER    = 16'd67;
	localparam logic [LEN_W-1:0]  INDEX_LIMIT    = 16'hFFFF;
	localparam logic [16:0]       SUM_START      = 17'h00011;

	// Offsets of interesting bytes relative to the start of the UDP header.
	localparam logic [LEN_W-1:0] REL_HLEN         = 16'd10;
	localparam logic [LEN_W-1:0] REL_CHADDR_FIRST = 16'd36;
	localparam logic [LEN_W-1:0] REL_CHADDR_LAST  = 16'd41;

	typedef struct packed {
		logic [BYTE_W-1:0]   out_byte;
		logic [STATUS_W-1:0] status;
		logic [CSUM_W-1:0]   udp_csum;
		logic [OFFS_W-1:0]   checksum_offset;
		logic [MAC_W-1:0]    original_mac;
	} dcr_result_t;

endpackage

// ----- design/dcr_in_if.sv -----
// Input stream interface: one packet byte per transaction.
`timescale 1ns / 1ps
interface dcr_in_if;
	logic                        valid;
	logic                        ready;
	logic [dcr_pkg::BYTE_W-1:0]  packet_byte;
	logic [dcr_pkg::LEN_W-1:0]   packet_length;
	logic                        last_byte;

	modport source (output valid, packet_byte, packet_length, last_byte, input ready);
	modport sink   (input valid, packet_byte, packet_length, last_byte, output ready);
endinterface

// ----- design/dcr_out_if.sv -----
// Output stream interface: one rewritten byte plus end-of-packet report per transaction.
`timescale 1ns / 1ps
interface dcr_out_if;
	logic                          valid;
	logic                          ready;
	logic [dcr_pkg::BYTE_W-1:0]    out_byte;
	logic                          out_last;
	logic [dcr_pkg::STATUS_W-1:0]  status;
	logic [dcr_pkg::CSUM_W-1:0]    udp_csum;
	logic [dcr_pkg::OFFS_W-1:0]    checksum_offset;
	logic [dcr_pkg::MAC_W-1:0]     original_mac;

	modport source (output valid, out_byte, out_last, status, udp_csum,
		checksum_offset, original_mac, input ready);
	modport sink   (input valid, out_byte, out_last, status, udp_csum,
		checksum_offset, original_mac, output ready);
endinterface

// ----- design/dcr_engine.sv -----
// Per-packet parse state, header checks, chaddr rewrite and UDP checksum accumulation.
`timescale 1ns / 1ps
module dcr_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step_en,
	input  logic [dcr_pkg::BYTE_W-1:0]   pkt_byte,
	input  logic [dcr_pkg::LEN_W-1:0]    pkt_len,
	input  logic                         pkt_last,
	input  logic [dcr_pkg::MAC_W-1:0]    new_mac,
	output dcr_pkg::dcr_result_t         result
);
	import dcr_pkg::*;

	logic [LEN_W-1:0]    idx_q, idx_n;
	logic [5:0]          ihb_q, ihb_n;
	logic [LEN_W-1:0]    sport_q, sport_n;
	logic [LEN_W-1:0]    ulen_q, ulen_n;
	logic [16:0]         sum_q, sum_n;
	logic [BYTE_W-1:0]   hold_q, hold_n;
	logic [STATUS_W-1:0] rej_q, rej_n;
	logic [MAC_W-1:0]    mac_q, mac_n;

	logic [LEN_W-1:0]    rel;
	logic [LEN_W-1:0]    dport;
	logic [LEN_W-1:0]    ihb_ext;
	logic [BYTE_W-1:0]   ob;
	logic [CSUM_W-1:0]   add_a, add_b, add_c;
	logic [18:0]         total;
	logic [16:0]         fold1;
	logic [15:0]         fold2;
	logic [15:0]         inv;
	logic [STATUS_W-1:0] code;

	always_comb begin
		idx_n   = idx_q;
		ihb_n   = ihb_q;
		sport_n = sport_q;
		ulen_n  = ulen_q;
		hold_n  = hold_q;
		rej_n   = rej_q;
		mac_n   = mac_q;
		ob      = pkt_byte;
		add_a   = '0;
		add_b   = '0;
		add_c   = '0;
		rel     = '0;
		dport   = '0;
		ihb_ext = {10'd0, ihb_q};

		if (idx_q != INDEX_LIMIT) begin
			if (idx_q == '0) begin
				ihb_n   = {pkt_byte[3:0], 2'b00};
				ihb_ext = {10'd0, ihb_n};
				if (pkt_len < MIN_PACKET)
					rej_n = ST_TOO_SHORT;
				else if (pkt_byte[7:4] != 4'd4 || ihb_ext < MIN_IP_HDR)
					rej_n = ST_BAD_HEADER;
				else if (ihb_ext + UDP_HDR_BYTES + DHCP_FIXED > pkt_len)
					rej_n = ST_TOO_SHORT;
			end
			if (idx_q == 16'd9 && rej_n == ST_REWRITTEN && pkt_byte != PROTO_UDP)
				rej_n = ST_NOT_UDP;
			// Pseudo-header: source and destination addresses.
			if (idx_q >= 16'd12 && idx_q <= 16'd19)
				add_a = idx_q[0] ? {8'd0, pkt_byte} : {pkt_byte, 8'd0};

			if (idx_q >= ihb_ext) begin
				rel = idx_q - ihb_ext;
				if (rej_n == ST_REWRITTEN) begin
					if (rel == REL_HLEN) begin
						ob = (new_mac == '0) ? 8'd0 : 8'd6;
					end else if (rel >= REL_CHADDR_FIRST && rel <= REL_CHADDR_LAST) begin
						mac_n = {mac_q[MAC_W-9:0], pkt_byte};
						case (rel[2:0])
							3'd4:    ob = new_mac[47:40];
							3'd5:    ob = new_mac[39:32];
							3'd6:    ob = new_mac[31:24];
							3'd7:    ob = new_mac[23:16];
							3'd0:    ob = new_mac[15:8];
							default: ob = new_mac[7:0];
						endcase
					end
				end
				if (rel <= 16'd5)
					add_b = rel[0] ? {8'd0, pkt_byte} : {pkt_byte, 8'd0};
				if (rel == 16'd0 || rel == 16'd2 || rel == 16'd4) begin
					hold_n = pkt_byte;
				end else if (rel == 16'd1) begin
					sport_n = {hold_q, pkt_byte};
				end else if (rel == 16'd3) begin
					dport = {hold_q, pkt_byte};
					if (rej_n == ST_REWRITTEN &&
						!((sport_q == PORT_CLIENT && dport == PORT_SERVER) ||
						  (sport_q == PORT_SERVER && dport == PORT_CLIENT)))
						rej_n = ST_NOT_DHCP;
				end else if (rel == 16'd5) begin
					ulen_n = {hold_q, pkt_byte};
					add_c  = ulen_n;
				end else if (rel >= UDP_HDR_BYTES && rel < ulen_q) begin
					add_b = rel[0] ? {8'd0, ob} : {ob, 8'd0};
				end
			end
			idx_n = idx_q + 16'd1;
		end

		// End-around carry sum; the value is never zero since it starts nonzero.
		total = {2'd0, sum_q} + {3'd0, add_a} + {3'd0, add_b} + {3'd0, add_c};
		sum_n = {1'b0, total[15:0]} + {14'd0, total[18:16]};

		fold1 = {1'b0, sum_n[15:0]} + {16'd0, sum_n[16]};
		fold2 = fold1[15:0] + {15'd0, fold1[16]};
		inv   = ~fold2;

		code = rej_n;
		if (code == ST_REWRITTEN && idx_n < ihb_ext + UDP_HDR_BYTES + DHCP_FIXED)
			code = ST_TOO_SHORT;

		result.out_byte        = ob;
		result.status          = '0;
		result.udp_csum        = '0;
		result.checksum_offset = '0;
		result.original_mac    = '0;
		if (pkt_last) begin
			result.status = code;
			if (code == ST_REWRITTEN) begin
				result.udp_csum        = (inv == '0) ? 16'hFFFF : inv;
				result.checksum_offset = {1'b0, ihb_n} + 7'd6;
				result.original_mac    = mac_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			ihb_q   <= '0;
			sport_q <= '0;
			ulen_q  <= '0;
			sum_q   <= SUM_START;
			hold_q  <= '0;
			rej_q   <= ST_REWRITTEN;
			mac_q   <= '0;
		end else if (step_en) begin
			if (pkt_last) begin
				idx_q   <= '0;
				ihb_q   <= '0;
				sport_q <= '0;
				ulen_q  <= '0;
				sum_q   <= SUM_START;
				hold_q  <= '0;
				rej_q   <= ST_REWRITTEN;
				mac_q   <= '0;
			end else begin
				idx_q   <= idx_n;
				ihb_q   <= ihb_n;
				sport_q <= sport_n;
				ulen_q  <= ulen_n;
				sum_q   <= sum_n;
				hold_q  <= hold_n;
				rej_q   <= rej_n;
				mac_q   <= mac_n;
			end
		end
	end

endmodule

// ----- design/dhcp_chaddr_rewriter_core.sv -----
// Top level of the DHCP chaddr rewriter: byte stream in, rewritten stream and report out.
//
//   Channel   Dir   Handshake          Carries
//   pkt_in    in    valid / ready      packet_byte, packet_length, last_byte
//   pkt_out   out   valid / ready      out_byte, out_last, status, checksum, offset, MAC
//   cfg       in    cfg_wr_en only     replacement MAC (48 bits)
//
// One byte enters per cycle while pkt_out is not stalled; every accepted byte
// leaves through the input register and then the result register.
// The per-packet parse state advances once per byte as it moves from the input
// register to the result register, so throughput is one byte per cycle without stalls.
// arst_n clears all control state and the replacement MAC.
// A stall on pkt_out holds the result register and then the input register;
// pkt_in.ready drops only when both are full.
`timescale 1ns / 1ps
module dhcp_chaddr_rewriter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	dcr_in_if.sink                        pkt_in,
	dcr_out_if.source                     pkt_out,
	input  logic                          cfg_wr_en,
	input  logic [dcr_pkg::MAC_W-1:0]     cfg_wr_data
);
	import dcr_pkg::*;

	// Configured MAC; the user must write it only while the block is idle, which the block does not enforce.
	logic [MAC_W-1:0] mac_q;

	// Input register.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [LEN_W-1:0]  len_s1;
	logic              last_s1;

	// Result register.
	logic              valid_s2;
	logic              last_s2;
	dcr_result_t       res_s2;

	dcr_result_t       res_comb;
	logic              out_free;
	logic              advance;

	// The result register can take a new byte when it is empty or being drained,
	// and the input register refills in the same cycle it hands its byte on.
	assign out_free     = !valid_s2 || pkt_out.ready;
	assign advance      = valid_s1 && out_free;
	assign pkt_in.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mac_q <= '0;
		else if (cfg_wr_en)
			mac_q <= cfg_wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pkt_in.ready)
				valid_s1 <= pkt_in.valid;
			if (out_free)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_in.valid && pkt_in.ready) begin
			byte_s1 <= pkt_in.packet_byte;
			len_s1  <= pkt_in.packet_length;
			last_s1 <= pkt_in.last_byte;
		end
		if (advance) begin
			res_s2  <= res_comb;
			last_s2 <= last_s1;
		end
	end

	// Header checks, rewrite and checksum for the byte in the input register.
	dcr_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (advance),
		.pkt_byte (byte_s1),
		.pkt_len  (len_s1),
		.pkt_last (last_s1),
		.new_mac  (mac_q),
		.result   (res_comb)
	);

	assign pkt_out.valid           = valid_s2;
	assign pkt_out.out_byte        = res_s2.out_byte;
	assign pkt_out.out_last        = last_s2;
	assign pkt_out.status          = res_s2.status;
	assign pkt_out.udp_csum        = res_s2.udp_csum;
	assign pkt_out.checksum_offset = res_s2.checksum_offset;
	assign pkt_out.original_mac    = res_s2.original_mac;

endmodule

// ----- sim/dhcp_chaddr_rewriter_core_tb.sv -----
// Self-checking testbench for the DHCP chaddr rewriter core with a built-in byte predictor.
`timescale 1ns / 1ps
module dhcp_chaddr_rewriter_core_tb;
	import dcr_pkg::*;

	// A packet must hold the UDP header and the fixed DHCP header after the IP header.
	localparam int AFTER_IP_MIN = UDP_HDR_BYTES + DHCP_FIXED;
	// Cycles without any transaction on either channel before the run is declared hung.
	// The longest legal quiet stretch is a sender gap plus a receiver stall plus a
	// register write.
	localparam int QUIET_LIMIT = 400;

	// One expected output transaction: the result record plus the end-of-packet flag.
	typedef struct packed {
		dcr_result_t res;
		logic        last;
	} byte_report_t;

	// Per-packet parse state of the predictor. It is a struct so that a whole
	// packet can be predicted ahead of time and the state put back afterwards.
	typedef struct {
		int          pos;
		int          hdr;
		logic [15:0] sport;
		logic [15:0] ulen;
		logic [31:0] acc;
		logic [7:0]  hold;
		logic [2:0]  rej;
		logic [47:0] seen_mac;
	} parse_state_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [MAC_W-1:0] cfg_wr_data;

	dcr_in_if  in_ch ();
	dcr_out_if out_ch ();

	dhcp_chaddr_rewriter_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pkt_in(in_ch),
		.pkt_out(out_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #6 clk = ~clk;

	parse_state_t   parser;
	logic [47:0]    mac_setting;
	byte_report_t   pending_out_q[$];
	logic [7:0]     frame_q[$];
	int             fail_count = 0;
	int             bytes_sent = 0;
	// While this is set both channels idle at random; it is cleared for the tail of the run.
	bit             pacing_on = 1'b1;

	// ---------------------------------------------------------------------------------
	// Predictor. The UDP checksum is kept as a folded one's complement sum and is
	// seeded with the protocol number, which is the fixed part of the pseudo-header.
	// ---------------------------------------------------------------------------------
	function automatic void clear_parser();
		parser.pos      = 0;
		parser.hdr      = 0;
		parser.sport    = '0;
		parser.ulen     = '0;
		parser.acc      = 32'(SUM_START);
		parser.hold     = '0;
		parser.rej      = ST_REWRITTEN;
		parser.seen_mac = '0;
	endfunction

	function automatic void fold_in(input logic [15:0] w);
		parser.acc = parser.acc + {16'd0, w};
		parser.acc = {16'd0, parser.acc[15:0]} + (parser.acc >> 16);
	endfunction

	// Bytes at even offsets are the high half of a 16-bit word.
	function automatic void fold_in_byte(input logic [7:0] b, input int rel);
		fold_in(rel[0] ? {8'd0, b} : {b, 8'd0});
	endfunction

	// Works out the output transaction caused by one accepted input byte.
	function automatic byte_report_t rewrite_byte(input logic [7:0] b, input logic [15:0] plen,
			input logic last);
		byte_report_t r;
		logic [7:0]  ob;
		logic [15:0] dport;
		logic [31:0] s;
		logic [15:0] inv;
		logic [2:0]  code;
		int          i;
		int          rel;
		r = '0;
		ob = b;
		i = parser.pos;
		// The byte counter saturates; anything past it passes through untouched.
		if (i < int'(INDEX_LIMIT)) begin
			if (i == 0) begin
				parser.hdr = 4 * int'(b[3:0]);
				if (plen < MIN_PACKET)
					parser.rej = ST_TOO_SHORT;
				else if (b[7:4] != 4'd4 || parser.hdr < int'(MIN_IP_HDR))
					parser.rej = ST_BAD_HEADER;
				else if (parser.hdr + AFTER_IP_MIN > int'(plen))
					parser.rej = ST_TOO_SHORT;
			end
			if (i == 9 && parser.rej == ST_REWRITTEN && b != PROTO_UDP)
				parser.rej = ST_NOT_UDP;
			// Source and destination addresses belong to the pseudo-header.
			if (i >= 12 && i <= 19)
				fold_in_byte(b, i - 12);
			if (i >= parser.hdr) begin
				rel = i - parser.hdr;
				if (parser.rej == ST_REWRITTEN) begin
					if (rel == int'(REL_HLEN)) begin
						ob = (mac_setting == '0) ? 8'd0 : 8'd6;
					end else if (rel >= int'(REL_CHADDR_FIRST) &&
							rel <= int'(REL_CHADDR_LAST)) begin
						parser.seen_mac = {parser.seen_mac[39:0], b};
						ob = mac_setting[(int'(REL_CHADDR_LAST) - rel) * 8 +: 8];
					end
				end
				if (rel <= 5)
					fold_in_byte(b, rel);
				if (rel == 0 || rel == 2 || rel == 4) begin
					parser.hold = b;
				end else if (rel == 1) begin
					parser.sport = {parser.hold, b};
				end else if (rel == 3) begin
					dport = {parser.hold, b};
					if (parser.rej == ST_REWRITTEN &&
							!((parser.sport == PORT_CLIENT && dport == PORT_SERVER) ||
							(parser.sport == PORT_SERVER && dport == PORT_CLIENT)))
						parser.rej = ST_NOT_DHCP;
				end else if (rel == 5) begin
					parser.ulen = {parser.hold, b};
					fold_in(parser.ulen);
				end else if (rel >= 8 && rel < int'(parser.ulen)) begin
					// The payload is summed as it leaves, after any rewrite.
					fold_in_byte(ob, rel);
				end
			end
			parser.pos = i + 1;
		end
		if (last) begin
			code = parser.rej;
			if (code == ST_REWRITTEN && parser.pos < parser.hdr + AFTER_IP_MIN)
				code = ST_TOO_SHORT;
			r.res.status = code;
			if (code == ST_REWRITTEN) begin
				s = parser.acc;
				while (s[31:16] != 16'd0)
					s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
				inv = ~s[15:0];
				// An all-zero checksum means "none" in UDP, so it goes out as all ones.
				r.res.udp_csum = (inv == 16'd0) ? 16'hFFFF : inv;
				r.res.checksum_offset = 7'(parser.hdr + 6);
				r.res.original_mac = parser.seen_mac;
			end
			clear_parser();
		end
		r.res.out_byte = ob;
		r.last = last;
		return r;
	endfunction

	// ---------------------------------------------------------------------------------
	// Driving. Every task starts and ends at a falling edge. Inputs change only there,
	// and handshakes are sampled at the rising edge, so no race with the block exists.
	// ---------------------------------------------------------------------------------

	// Sends one byte and records what should come out for it. The valid line stays
	// high after the transaction, so back-to-back bytes need no extra assignment.
	task automatic send_byte(input logic [7:0] b, input logic [15:0] plen, input logic last);
		byte_report_t want;
		if (pacing_on && $urandom_range(0, 11) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.packet_byte   <= b;
		in_ch.packet_length <= plen;
		in_ch.last_byte     <= last;
		@(posedge clk);
		while (in_ch.ready !== 1'b1)
			@(posedge clk);
		want = rewrite_byte(b, plen, last);
		pending_out_q.insert(pending_out_q.size(), want);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [15:0] plen);
		for (int k = 0; k < frame_q.size(); k++)
			send_byte(frame_q[k], plen, k == frame_q.size() - 1);
	endtask

	// Trims the frame to its first n bytes and sends it, for packets that end early.
	task automatic send_cut(input int n, input logic [15:0] plen);
		while (frame_q.size() > n)
			void'(frame_q.pop_back());
		send_frame(plen);
	endtask

	// Holds the sender until every expected transaction has come out, then lets the
	// two pipeline stages settle.
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (pending_out_q.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_mac(input logic [47:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		mac_setting = value;
		@(negedge clk);
	endtask

	// Builds a well-formed IPv4/UDP frame of nbytes random bytes with the given header
	// length in words, ports and UDP length field.
	task automatic build_dhcp_frame(input int ihl, input int nbytes, input logic [15:0] sport,
			input logic [15:0] dport, input logic [15:0] ulen);
		int base;
		frame_q.delete();
		for (int k = 0; k < nbytes; k++)
			frame_q.insert(frame_q.size(), 8'($urandom()));
		base = ihl * 4;
		frame_q[0] = {4'd4, 4'(ihl)};
		frame_q[2] = nbytes[15:8];
		frame_q[3] = nbytes[7:0];
		frame_q[9] = PROTO_UDP;
		frame_q[base + 0] = sport[15:8];
		frame_q[base + 1] = sport[7:0];
		frame_q[base + 2] = dport[15:8];
		frame_q[base + 3] = dport[7:0];
		frame_q[base + 4] = ulen[15:8];
		frame_q[base + 5] = ulen[7:0];
	endtask

	// ---------------------------------------------------------------------------------
	// Tests.
	// ---------------------------------------------------------------------------------

	// Right after reset the replacement MAC is zero, so hlen goes to 0 and chaddr
	// is cleared. The reply direction of the ports is used here.
	task automatic test_zero_mac_after_reset();
		build_dhcp_frame(5, 264, PORT_SERVER, PORT_CLIENT, 16'd244);
		send_frame(16'd264);
	endtask

	// Longest IP header with options, an odd UDP length that stops short of the
	// frame end, and an all-ones MAC over an all-zero chaddr.
	task automatic test_option_header_rewrite();
		build_dhcp_frame(15, 315, PORT_CLIENT, PORT_SERVER, 16'd251);
		for (int k = 60 + 36; k <= 60 + 41; k++)
			frame_q[k] = 8'h00;
		send_frame(16'd315);
	endtask

	// A UDP length below the header size counts only the pseudo-header and the first
	// six UDP bytes; one beyond the frame counts the missing bytes as zero.
	task automatic test_udp_length_edges();
		build_dhcp_frame(5, 264, PORT_CLIENT, PORT_SERVER, 16'd3);
		send_frame(16'd264);
		build_dhcp_frame(5, 265, PORT_SERVER, PORT_CLIENT, 16'hFFFF);
		send_frame(16'd265);
	endtask

	// Tunes the first DHCP word so that the one's complement sum comes to all ones.
	// The inverted sum is then zero and must be reported as all ones instead.
	task automatic test_checksum_wraps_to_ones();
		parse_state_t saved;
		byte_report_t trial;
		logic [16:0]  w;
		build_dhcp_frame(5, 270, PORT_CLIENT, PORT_SERVER, 16'd250);
		saved = parser;
		foreach (frame_q[k])
			trial = rewrite_byte(frame_q[k], 16'd270, k == frame_q.size() - 1);
		parser = saved;
		w = {1'b0, frame_q[28], frame_q[29]} + {1'b0, trial.res.udp_csum};
		w = {1'b0, w[15:0]} + {16'd0, w[16]};
		frame_q[28] = w[15:8];
		frame_q[29] = w[7:0];
		send_frame(16'd270);
	endtask

	// Each rejection reason, plus packets that end before the DHCP header is complete.
	task automatic test_header_rejects();
		// Declared length below the minimum for any DHCP packet.
		build_dhcp_frame(5, 264, PORT_CLIENT, PORT_SERVER, 16'd244);
		send_cut(3, MIN_PACKET - 16'd1);
		// Wrong IP version.
		build_dhcp_frame(5, 264, PORT_CLIENT, PORT_SERVER, 16'd244);
		frame_q[0] = 8'h65;
		send_cut(12, 16'd300);
		// Header length below five words; the UDP fields then sit at the wrong place.
		build_dhcp_frame(5, 264, PORT_CLIENT, PORT_SERVER, 16'd244);
		frame_q[0] = 8'h44;
		send_cut(30, 16'd300);
		// Not UDP.
		build_dhcp_frame(5, 264, PORT_CLIENT, PORT_SERVER, 16'd244);
		frame_q[9] = 8'h06;
		send_cut(24, 16'd300);
		// Both ports are the client port.
		build_dhcp_frame(5, 264, PORT_CLIENT, PORT_CLIENT, 16'd244);
		send_cut(30, 16'd300);
		// Declared length too small for the option-sized header.
		build_dhcp_frame(15, 304, PORT_CLIENT, PORT_SERVER, 16'd244);
		send_cut(10, 16'd303);
		// Good header, but the packet ends in the middle of chaddr.
		build_dhcp_frame(5, 264, PORT_SERVER, PORT_CLIENT, 16'd244);
		send_cut(60, 16'd264);
		// Single-byte packets with the largest and the smallest declared length.
		frame_q.delete();
		frame_q.insert(0, 8'h45);
		send_frame(16'hFFFF);
		frame_q[0] = 8'h00;
		send_frame(16'h0000);
	endtask

	// Mostly well-formed DHCP packets with random content, with some broken ones and
	// some plain noise mixed in, until about budget bytes have gone in.
	task automatic test_random_traffic(input int budget);
		int          stop_at;
		int          kind;
		int          ihl;
		int          nbytes;
		int          v;
		logic [15:0] ulen;
		logic [15:0] plen;
		stop_at = bytes_sent + budget;
		while (bytes_sent < stop_at) begin
			kind = $urandom_range(0, 9);
			if (kind <= 7) begin
				ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
				nbytes = ihl * 4 + AFTER_IP_MIN + $urandom_range(0, 24);
				ulen = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'(nbytes - ihl * 4);
				if ($urandom_range(0, 1) == 0)
					build_dhcp_frame(ihl, nbytes, PORT_CLIENT, PORT_SERVER, ulen);
				else
					build_dhcp_frame(ihl, nbytes, PORT_SERVER, PORT_CLIENT, ulen);
				plen = 16'(nbytes);
				if (kind >= 6) begin
					// Break the packet in one way.
					case ($urandom_range(0, 5))
						0: begin
							v = $urandom_range(0, 14);
							if (v >= 4)
								v++;
							frame_q[0][7:4] = 4'(v);
						end
						1: frame_q[0][3:0] = 4'($urandom_range(0, 4));
						2: frame_q[9] = frame_q[9] ^ 8'($urandom_range(1, 255));
						3: frame_q[ihl * 4 + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
						4: plen = 16'($urandom_range(0, int'(MIN_PACKET) - 1));
						default: send_cut($urandom_range(1, nbytes - 1), plen);
					endcase
				end
				if (frame_q.size() != 0 && (kind < 6 || frame_q.size() == nbytes))
					send_frame(plen);
			end else begin
				frame_q.delete();
				nbytes = $urandom_range(1, 30);
				for (int k = 0; k < nbytes; k++)
					frame_q.insert(frame_q.size(), 8'($urandom()));
				send_frame(16'($urandom()));
			end
		end
	endtask

	// ---------------------------------------------------------------------------------
	// Receiver: random stall bursts on ready while pacing is on.
	// ---------------------------------------------------------------------------------
	initial begin : sink_pacing
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (pacing_on && $urandom_range(0, 9) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	function automatic void compare_field(input string what, input logic [47:0] want_v,
			input logic [47:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
			fail_count++;
		end
	endfunction

	// Every output transaction is checked against the oldest expected byte.
	always @(posedge clk) begin : result_check
		byte_report_t want;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (pending_out_q.size() == 0) begin
				$display("%0t: unexpected output byte %h", $time, out_ch.out_byte);
				fail_count++;
			end else begin
				want = pending_out_q.pop_front();
				compare_field("out_byte", 48'(want.res.out_byte), 48'(out_ch.out_byte));
				compare_field("out_last", 48'(want.last), 48'(out_ch.out_last));
				compare_field("status", 48'(want.res.status), 48'(out_ch.status));
				compare_field("udp_csum", 48'(want.res.udp_csum), 48'(out_ch.udp_csum));
				compare_field("checksum_offset", 48'(want.res.checksum_offset),
					48'(out_ch.checksum_offset));
				compare_field("original_mac", want.res.original_mac, out_ch.original_mac);
			end
		end
	end

	// The run is declared hung once no transaction happens for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
					(out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// ---------------------------------------------------------------------------------
	// Test sequence. Register writes happen only once the block has gone quiet.
	// ---------------------------------------------------------------------------------
	initial begin : run_tests
		arst_n              = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_wr_data         = '0;
		in_ch.valid         = 1'b0;
		in_ch.packet_byte   = '0;
		in_ch.packet_length = '0;
		in_ch.last_byte     = 1'b0;
		mac_setting         = '0;
		clear_parser();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_zero_mac_after_reset();
		drain_results();
		write_mac(48'hFFFF_FFFF_FFFF);
		test_option_header_rewrite();
		test_checksum_wraps_to_ones();
		test_header_rejects();

		drain_results();
		write_mac({16'($urandom()), 32'($urandom())});
		test_random_traffic(150);

		// The last part runs without idling on either side.
		pacing_on = 1'b0;
		drain_results();
		write_mac(48'h8000_0000_0000);
		while (out_ch.ready !== 1'b1)
			@(negedge clk);
		test_udp_length_edges();

		drain_results();
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/dcr_pkg.sv
design/dcr_in_if.sv
design/dcr_out_if.sv
design/dcr_engine.sv
design/dhcp_chaddr_rewriter_core.sv
sim/dhcp_chaddr_rewriter_core_tb.sv
